// ----- rtl/core/matrix3x3_inverse_assert.svh -----
// assertion macros for the 3x3 inverse block
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define M3I_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define M3I_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/minv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_pkg
// types, widths and cofactor index tables for the 3x3 inverse pipeline
// ----------------------------------------------------------------------------
package minv_pkg;

    localparam int IW     = 20;   // input element, signed Q3.16
    localparam int PW     = 40;   // element product
    localparam int AW     = 41;   // cofactor, signed Q.32
    localparam int NW     = 40;   // cofactor magnitude
    localparam int DW     = 61;   // determinant, signed Q.48
    localparam int DMW    = 60;   // determinant magnitude
    localparam int OW     = 32;   // result element, signed Q15.16
    localparam int QW     = 33;   // quotient bits kept
    localparam int NLANE  = 9;
    localparam int QSTEPS = 32;

    localparam int ST_FRONT = 2;
    localparam int ST_DET   = 4;
    localparam int ST_DIV   = QSTEPS + 1;
    localparam int ST_OUT   = 1;
    localparam int NSTG     = ST_FRONT + ST_DET + ST_DIV + ST_OUT;

    // cofactor k = a[CF_A]*a[CF_B] - a[CF_C]*a[CF_D], element index row*3+col
    localparam logic [3:0] CF_A [NLANE] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam logic [3:0] CF_B [NLANE] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam logic [3:0] CF_C [NLANE] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
    localparam logic [3:0] CF_D [NLANE] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

    typedef logic signed [IW-1:0] elem_t;
    typedef logic signed [AW-1:0] adj_t;
    typedef logic signed [OW-1:0] res_t;

    typedef struct packed {
        elem_t m00;
        elem_t m01;
        elem_t m02;
        elem_t m10;
        elem_t m11;
        elem_t m12;
        elem_t m20;
        elem_t m21;
        elem_t m22;
    } req_t;

    typedef struct packed {
        res_t r00;
        res_t r01;
        res_t r02;
        res_t r10;
        res_t r11;
        res_t r12;
        res_t r20;
        res_t r21;
        res_t r22;
        logic singular;
        logic clipped;
    } rsp_t;

endpackage

// ----- rtl/core/matrix3x3_inverse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 Q3.16 matrix inverse by adjugate over determinant, Q15.16 saturated
// ----------------------------------------------------------------------------
// usage
//   req/req_valid/req_ready carry one matrix word, rsp/rsp_valid/rsp_ready
//   carry one inverse word with singular and clipped flags
//   a word moves when valid and ready are both high at a rising clk edge
// pipeline and throughput
//   40 register stages: 2 cofactor stages, 4 determinant stages,
//   33 divider stages (one quotient bit per stage, nine lanes sharing
//   the divisor) and the output register
//   rsp_valid rises once the word is held in the output register
//   one word per cycle sustained while rsp_ready stays high
// reset
//   rst_n clears all stage valid bits; the pipe is empty afterward
// stall
//   each stage holds only while it and every stage after it are full and
//   rsp_ready is low, so bubbles close up and req_ready stays high until
//   the whole pipe is full behind a stalled output word
// ----------------------------------------------------------------------------
module matrix3x3_inverse
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  minv_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output minv_pkg::rsp_t   rsp
);
    import minv_pkg::*;

    localparam int E_DET = ST_FRONT;
    localparam int E_DIV = ST_FRONT + ST_DET;
    localparam int E_OUT = E_DIV + ST_DIV;

    logic [NSTG-1:0]  v_reg;
    logic [NSTG-1:0]  v_next;
    logic [NSTG-1:0]  en;

    adj_t             adj [NLANE];
    elem_t            row0 [3];
    logic [NW-1:0]    mag [NLANE];
    logic [NLANE-1:0] neg;
    logic [DMW-1:0]   dmag;
    logic             zero;
    logic [QW-1:0]    quo [NLANE];
    logic [NLANE-1:0] huge;
    logic [NLANE-1:0] qneg;
    logic             qzero;

    // stage k moves unless it and all later stages are full and output stalls
    for (genvar k = 0; k < NSTG; k++)
    begin : g_ctl
        assign en[k] = rsp_ready || !(&v_reg[NSTG-1:k]);
        if (k == 0)
        begin : g_head
            assign v_next[k] = en[k] ? req_valid : v_reg[k];
        end
        else
        begin : g_body
            assign v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign req_ready = en[0];
    assign rsp_valid = v_reg[NSTG-1];

    minv_front u_front
    (
        .clk  (clk),
        .en   (en[E_DET-1:0]),
        .req  (req),
        .adj  (adj),
        .row0 (row0)
    );

    minv_det u_det
    (
        .clk  (clk),
        .en   (en[E_DIV-1:E_DET]),
        .adj  (adj),
        .row0 (row0),
        .mag  (mag),
        .neg  (neg),
        .dmag (dmag),
        .zero (zero)
    );

    minv_div u_div
    (
        .clk   (clk),
        .en    (en[E_OUT-1:E_DIV]),
        .mag   (mag),
        .neg   (neg),
        .dmag  (dmag),
        .zero  (zero),
        .quo   (quo),
        .huge  (huge),
        .qneg  (qneg),
        .qzero (qzero)
    );

    minv_out u_out
    (
        .clk   (clk),
        .en    (en[E_OUT]),
        .quo   (quo),
        .huge  (huge),
        .qneg  (qneg),
        .qzero (qzero),
        .rsp   (rsp)
    );

endmodule

// ----- rtl/core/minv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_front
// element products and the nine cofactors, two register stages
// ----------------------------------------------------------------------------
module minv_front
(
    input  logic                                  clk,
    input  logic [minv_pkg::ST_FRONT-1:0]         en,
    input  minv_pkg::req_t                        req,
    output minv_pkg::adj_t                        adj [minv_pkg::NLANE],
    output minv_pkg::elem_t                       row0 [3]
);
    import minv_pkg::*;

    elem_t                a [NLANE];
    logic signed [PW-1:0] pab_reg [NLANE];
    logic signed [PW-1:0] pcd_reg [NLANE];
    adj_t                 adj_reg [NLANE];
    elem_t                r0a_reg [3];
    elem_t                r0b_reg [3];

    assign a[0] = req.m00;
    assign a[1] = req.m01;
    assign a[2] = req.m02;
    assign a[3] = req.m10;
    assign a[4] = req.m11;
    assign a[5] = req.m12;
    assign a[6] = req.m20;
    assign a[7] = req.m21;
    assign a[8] = req.m22;

    for (genvar i = 0; i < NLANE; i++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                pab_reg[i] <= a[CF_A[i]] * a[CF_B[i]];
                pcd_reg[i] <= a[CF_C[i]] * a[CF_D[i]];
            end
            if (en[1])
            begin
                adj_reg[i] <= AW'(pab_reg[i]) - AW'(pcd_reg[i]);
            end
        end
        assign adj[i] = adj_reg[i];
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_row0
        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                r0a_reg[k] <= a[k];
            end
            if (en[1])
            begin
                r0b_reg[k] <= r0a_reg[k];
            end
        end
        assign row0[k] = r0b_reg[k];
    end

endmodule

// ----- rtl/core/minv_det.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_det
// determinant by row-0 expansion with split multiplies, then magnitudes
// ----------------------------------------------------------------------------
module minv_det
(
    input  logic                                  clk,
    input  logic [minv_pkg::ST_DET-1:0]           en,
    input  minv_pkg::adj_t                        adj [minv_pkg::NLANE],
    input  minv_pkg::elem_t                       row0 [3],
    output logic [minv_pkg::NW-1:0]               mag [minv_pkg::NLANE],
    output logic [minv_pkg::NLANE-1:0]            neg,
    output logic [minv_pkg::DMW-1:0]              dmag,
    output logic                                  zero
);
    import minv_pkg::*;

    localparam int LB  = 21;          // low slice of the cofactor
    localparam int PLW = IW + LB + 1;
    localparam int PHW = IW + AW - LB;
    localparam int SLW = PLW + 2;
    localparam int SHW = PHW + 2;

    logic signed [PLW-1:0] pl_reg [3];
    logic signed [PHW-1:0] ph_reg [3];
    logic signed [SLW-1:0] sl_reg;
    logic signed [SHW-1:0] sh_reg;
    logic signed [DW-1:0]  det_reg;
    adj_t                  adj3_reg [NLANE];
    adj_t                  adj4_reg [NLANE];
    adj_t                  adj5_reg [NLANE];
    logic [NW-1:0]         mag_reg [NLANE];
    logic [NLANE-1:0]      neg_reg;
    logic [DMW-1:0]        dmag_reg;
    logic                  zero_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_part
        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                pl_reg[k] <= row0[k] * $signed({1'b0, adj[3*k][LB-1:0]});
                ph_reg[k] <= row0[k] * $signed(adj[3*k][AW-1:LB]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sl_reg <= SLW'(pl_reg[0]) + SLW'(pl_reg[1]) + SLW'(pl_reg[2]);
            sh_reg <= SHW'(ph_reg[0]) + SHW'(ph_reg[1]) + SHW'(ph_reg[2]);
        end
        if (en[2])
        begin
            det_reg <= DW'((64'(sh_reg) <<< LB) + 64'(sl_reg));
        end
        if (en[3])
        begin
            dmag_reg <= DMW'(det_reg[DW-1] ? -det_reg : det_reg);
            zero_reg <= (det_reg == '0);
        end
    end

    for (genvar i = 0; i < NLANE; i++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                adj3_reg[i] <= adj[i];
            end
            if (en[1])
            begin
                adj4_reg[i] <= adj3_reg[i];
            end
            if (en[2])
            begin
                adj5_reg[i] <= adj4_reg[i];
            end
            if (en[3])
            begin
                mag_reg[i] <= NW'(adj5_reg[i][AW-1] ? -adj5_reg[i] : adj5_reg[i]);
                neg_reg[i] <= adj5_reg[i][AW-1] ^ det_reg[DW-1];
            end
        end
        assign mag[i] = mag_reg[i];
    end

    assign neg  = neg_reg;
    assign dmag = dmag_reg;
    assign zero = zero_reg;

endmodule

// ----- rtl/core/minv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_div
// nine restoring dividers sharing the divisor, one quotient bit per stage
// ----------------------------------------------------------------------------
module minv_div
(
    input  logic                                  clk,
    input  logic [minv_pkg::ST_DIV-1:0]           en,
    input  logic [minv_pkg::NW-1:0]               mag [minv_pkg::NLANE],
    input  logic [minv_pkg::NLANE-1:0]            neg,
    input  logic [minv_pkg::DMW-1:0]              dmag,
    input  logic                                  zero,
    output logic [minv_pkg::QW-1:0]               quo [minv_pkg::NLANE],
    output logic [minv_pkg::NLANE-1:0]            huge,
    output logic [minv_pkg::NLANE-1:0]            qneg,
    output logic                                  qzero
);
    import minv_pkg::*;

    logic [DMW-1:0]   rem_reg  [ST_DIV][NLANE];
    logic [QW-1:0]    quo_reg  [ST_DIV][NLANE];
    logic [DMW-1:0]   d_reg    [ST_DIV];
    logic [NLANE-1:0] huge_reg [ST_DIV];
    logic [NLANE-1:0] neg_reg  [ST_DIV];
    logic             zero_reg [ST_DIV];

    // first stage: overflow test and integer quotient bit
    for (genvar i = 0; i < NLANE; i++)
    begin : g_first
        logic [DMW:0] nx;
        logic         ge;
        assign nx = (DMW+1)'(mag[i]);
        assign ge = nx >= {1'b0, dmag};
        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                huge_reg[0][i] <= nx >= {dmag, 1'b0};
                rem_reg[0][i]  <= ge ? DMW'(nx - {1'b0, dmag}) : DMW'(nx);
                quo_reg[0][i]  <= QW'(ge);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg[0]    <= dmag;
            neg_reg[0]  <= neg;
            zero_reg[0] <= zero;
        end
    end

    // fractional quotient bits
    for (genvar s = 1; s < ST_DIV; s++)
    begin : g_step
        for (genvar i = 0; i < NLANE; i++)
        begin : g_lane
            logic [DMW:0] r2;
            logic         ge;
            assign r2 = {rem_reg[s-1][i], 1'b0};
            assign ge = r2 >= {1'b0, d_reg[s-1]};
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s][i] <= ge ? DMW'(r2 - {1'b0, d_reg[s-1]}) : DMW'(r2);
                    quo_reg[s][i] <= {quo_reg[s-1][i][QW-2:0], ge};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                d_reg[s]    <= d_reg[s-1];
                huge_reg[s] <= huge_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    for (genvar i = 0; i < NLANE; i++)
    begin : g_out
        assign quo[i] = quo_reg[ST_DIV-1][i];
    end

    assign huge  = huge_reg[ST_DIV-1];
    assign qneg  = neg_reg[ST_DIV-1];
    assign qzero = zero_reg[ST_DIV-1];

endmodule

// ----- rtl/core/minv_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_out
// sign, saturation and singular handling into the output word register
// ----------------------------------------------------------------------------
module minv_out
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [minv_pkg::QW-1:0]               quo [minv_pkg::NLANE],
    input  logic [minv_pkg::NLANE-1:0]            huge,
    input  logic [minv_pkg::NLANE-1:0]            qneg,
    input  logic                                  qzero,
    output minv_pkg::rsp_t                        rsp
);
    import minv_pkg::*;

    localparam logic [QW-1:0] POS_LIM = QW'({1'b0, {(OW-1){1'b1}}});
    localparam logic [QW-1:0] NEG_LIM = QW'({1'b1, {(OW-1){1'b0}}});
    localparam res_t          SAT_P   = {1'b0, {(OW-1){1'b1}}};
    localparam res_t          SAT_N   = {1'b1, {(OW-1){1'b0}}};

    res_t             val [NLANE];
    logic [NLANE-1:0] sat;
    rsp_t             rsp_next;
    rsp_t             rsp_reg;

    for (genvar i = 0; i < NLANE; i++)
    begin : g_lane
        always_comb
        begin
            if (qneg[i])
            begin
                sat[i] = huge[i] || (quo[i] > NEG_LIM);
                val[i] = sat[i] ? SAT_N : OW'(-quo[i]);
            end
            else
            begin
                sat[i] = huge[i] || (quo[i] > POS_LIM);
                val[i] = sat[i] ? SAT_P : OW'(quo[i]);
            end
        end
    end

    always_comb
    begin
        rsp_next.r00      = qzero ? '0 : val[0];
        rsp_next.r01      = qzero ? '0 : val[1];
        rsp_next.r02      = qzero ? '0 : val[2];
        rsp_next.r10      = qzero ? '0 : val[3];
        rsp_next.r11      = qzero ? '0 : val[4];
        rsp_next.r12      = qzero ? '0 : val[5];
        rsp_next.r20      = qzero ? '0 : val[6];
        rsp_next.r21      = qzero ? '0 : val[7];
        rsp_next.r22      = qzero ? '0 : val[8];
        rsp_next.singular = qzero;
        rsp_next.clipped  = !qzero && (|sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ----- rtl/core/minv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv_checker
// port-level checks for the 3x3 inverse block, bound to the top level
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_assert.svh"

module minv_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  minv_pkg::rsp_t   rsp
);
    import minv_pkg::*;

    logic rsp_all_zero;

    assign rsp_all_zero = (rsp.r00 == '0) && (rsp.r01 == '0) && (rsp.r02 == '0)
                       && (rsp.r10 == '0) && (rsp.r11 == '0) && (rsp.r12 == '0)
                       && (rsp.r20 == '0) && (rsp.r21 == '0) && (rsp.r22 == '0);

    // stalled output word holds
    `M3I_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp word changed while stalled")

    // input only backs up behind a stalled output word
    `M3I_ASSERT_IMP(a_req_stall, !req_ready, rsp_valid && !rsp_ready, "req_ready low without output stall")

    // singular word is all zeros and never clipped
    `M3I_ASSERT_IMP(a_singular, rsp_valid && rsp.singular, rsp_all_zero && !rsp.clipped, "singular word not clean")

    // waiting input word stays offered
    `M3I_ASSERT_NXT(a_req_hold, req_valid && !req_ready, req_valid, "req_valid dropped while waiting")

endmodule

bind matrix3x3_inverse minv_checker u_minv_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 3x3 fixed-point matrix inverse pipeline
// ----------------------------------------------------------------------------
// matrix words go in through a bursty driver; each accepted word is inverted
// by an exact adjugate/determinant model and queued, and the monitor checks
// every inverse word against the oldest queued one under a stalling receiver
// ----------------------------------------------------------------------------
module tb_top;
    import minv_pkg::*;

    localparam int LATENCY  = 40;
    localparam int WDOG_MAX = 20000;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    rsp_t  rsp;

    req_t  matrix_q[$];
    rsp_t  inverse_q[$];
    int    mismatches;
    int    wdog;
    int    burst_left;
    int    gap_left;
    int    stall_cnt;
    bit    hold_off;

    matrix3x3_inverse dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // (num * 2^32) / den, truncated toward zero, saturated to 32 bits
    function automatic res_t quot_sat(input logic signed [40:0] num,
                                      input logic signed [60:0] den,
                                      inout bit clip);
        logic signed [127:0] n;
        logic signed [127:0] d;
        logic signed [127:0] q;
        n = 128'(num) <<< 32;
        d = 128'(den);
        q = n / d;
        if (q > 128'sh7FFFFFFF)
        begin
            clip = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (q < -128'sh80000000)
        begin
            clip = 1'b1;
            return 32'h80000000;
        end
        return q[31:0];
    endfunction

    function automatic rsp_t invert(input req_t m);
        logic signed [63:0] a [9];
        logic signed [63:0] adj [9];
        logic signed [63:0] det;
        rsp_t r;
        bit clip;
        a[0] = m.m00; a[1] = m.m01; a[2] = m.m02;
        a[3] = m.m10; a[4] = m.m11; a[5] = m.m12;
        a[6] = m.m20; a[7] = m.m21; a[8] = m.m22;
        det = a[0]*a[4]*a[8] + a[1]*a[5]*a[6] + a[2]*a[3]*a[7]
            - a[6]*a[4]*a[2] - a[7]*a[5]*a[0] - a[8]*a[3]*a[1];
        adj[0] = a[4]*a[8] - a[7]*a[5];
        adj[1] = a[7]*a[2] - a[1]*a[8];
        adj[2] = a[1]*a[5] - a[4]*a[2];
        adj[3] = a[6]*a[5] - a[3]*a[8];
        adj[4] = a[0]*a[8] - a[6]*a[2];
        adj[5] = a[3]*a[2] - a[0]*a[5];
        adj[6] = a[3]*a[7] - a[6]*a[4];
        adj[7] = a[6]*a[1] - a[0]*a[7];
        adj[8] = a[0]*a[4] - a[3]*a[1];
        r = '0;
        clip = 1'b0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        r.r00 = quot_sat(adj[0][40:0], det[60:0], clip);
        r.r01 = quot_sat(adj[1][40:0], det[60:0], clip);
        r.r02 = quot_sat(adj[2][40:0], det[60:0], clip);
        r.r10 = quot_sat(adj[3][40:0], det[60:0], clip);
        r.r11 = quot_sat(adj[4][40:0], det[60:0], clip);
        r.r12 = quot_sat(adj[5][40:0], det[60:0], clip);
        r.r20 = quot_sat(adj[6][40:0], det[60:0], clip);
        r.r21 = quot_sat(adj[7][40:0], det[60:0], clip);
        r.r22 = quot_sat(adj[8][40:0], det[60:0], clip);
        r.clipped = clip;
        return r;
    endfunction

    function automatic elem_t rand_elem(input int mode);
        case (mode)
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(0, 4096)) - 20'sd2048;
            2: return ($urandom_range(0, 1) ? 20'sh80000 : 20'sh7FFFF);
            default: return ($urandom_range(0, 1) ? elem_t'($urandom_range(32768, 98304))
                                                  : -elem_t'($urandom_range(32768, 98304)));
        endcase
    endfunction

    function automatic req_t diag(input elem_t x, input elem_t y, input elem_t z);
        req_t m;
        m = '0;
        m.m00 = x; m.m11 = y; m.m22 = z;
        return m;
    endfunction

    function automatic req_t rand_matrix();
        req_t m;
        int mode;
        int shape;
        mode = $urandom_range(0, 3);
        shape = $urandom_range(0, 9);
        m.m00 = rand_elem(mode); m.m01 = rand_elem(mode); m.m02 = rand_elem(mode);
        m.m10 = rand_elem(mode); m.m11 = rand_elem(mode); m.m12 = rand_elem(mode);
        m.m20 = rand_elem(mode); m.m21 = rand_elem(mode); m.m22 = rand_elem(mode);
        if (shape == 0)
        begin
            m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
        end
        else if (shape == 1)
        begin
            m.m01 = 0; m.m02 = 0; m.m10 = 0; m.m12 = 0; m.m20 = 0; m.m21 = 0;
        end
        else if (shape == 2)
        begin
            // diagonal entries set near 1.0, off-diagonal entries left as drawn
            m.m00 = 20'sd65536 + rand_elem(1); m.m11 = 20'sd65536 + rand_elem(1);
            m.m22 = 20'sd65536 + rand_elem(1);
        end
        return m;
    endfunction

    initial
    begin
        req_t m;
        rst_n = 1'b0;
        hold_off = 1'b0;
        m = '0;
        matrix_q.push_back(m);
        matrix_q.push_back(diag(20'sd65536, 20'sd65536, 20'sd65536));
        matrix_q.push_back(diag(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF));
        matrix_q.push_back(diag(20'sh80000, 20'sh80000, 20'sh80000));
        matrix_q.push_back(diag(20'sd1, 20'sd1, 20'sd1));
        matrix_q.push_back(diag(-20'sd1, 20'sd1, 20'sd1));
        matrix_q.push_back(diag(20'sd1, 20'sd65536, 20'sd65536));
        matrix_q.push_back(diag(-20'sd1, 20'sd65536, 20'sd65536));
        matrix_q.push_back(diag(20'sd2, 20'sd65536, 20'sd65536));
        matrix_q.push_back(diag(-20'sd2, 20'sd65536, 20'sd65536));
        matrix_q.push_back(diag(20'sd32768, 20'sd32768, 20'sd32768));
        matrix_q.push_back(diag(20'sh80000, 20'sd3, 20'sd65536));
        m = '{default: 20'sh7FFFF};
        matrix_q.push_back(m);
        m = '{default: 20'sh80000};
        matrix_q.push_back(m);
        m = '{m00: 20'sh80000, m01: 20'sh7FFFF, m02: 20'sh80000,
              m10: 20'sh7FFFF, m11: 20'sh80000, m12: 20'sh7FFFF,
              m20: 20'sh80000, m21: 20'sh7FFFF, m22: 20'sh7FFFF};
        matrix_q.push_back(m);
        m = '{m00: 0, m01: 20'sd65536, m02: 0, m10: 0, m11: 0, m12: 20'sd65536,
              m20: 20'sd65536, m21: 0, m22: 0};
        matrix_q.push_back(m);
        m = '{m00: 20'sh7FFFF, m01: 20'sh80000, m02: 20'sh7FFFF,
              m10: 20'sh80000, m11: 20'sh7FFFF, m12: 20'sh80000,
              m20: 20'sd1, m21: -20'sd1, m22: 20'sd1};
        matrix_q.push_back(m);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 600; i++)
            matrix_q.push_back(rand_matrix());
        wait (matrix_q.size() == 0);
        // let the pipe drain completely before the second half
        hold_off = 1'b1;
        wait (!req_valid && inverse_q.size() == 0);
        hold_off = 1'b0;
        for (int i = 0; i < 600; i++)
            matrix_q.push_back(rand_matrix());
        wait (matrix_q.size() == 0 && !req_valid && inverse_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && inverse_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                inverse_q.push_back(invert(req));
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (matrix_q.size() > 0 && !hold_off)
                begin
                    req       <= matrix_q.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_w;
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            stall_cnt  <= 0;
            mismatches <= 0;
            wdog       <= 0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
            rsp_ready <= (stall_cnt % 300 < 100) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                wdog <= 0;
            else
            begin
                wdog <= wdog + 1;
                if (wdog >= WDOG_MAX)
                begin
                    $display("tb_top: FAIL");
                    $finish;
                end
            end
            if (rsp_valid && rsp_ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected inverse word %h", rsp);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_w = inverse_q.pop_front();
                    if (rsp !== exp_w)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("inverse mismatch exp r %h %h %h %h %h %h %h %h %h s%b c%b",
                                     exp_w.r00, exp_w.r01, exp_w.r02, exp_w.r10, exp_w.r11,
                                     exp_w.r12, exp_w.r20, exp_w.r21, exp_w.r22,
                                     exp_w.singular, exp_w.clipped);
                            $display("                 got r %h %h %h %h %h %h %h %h %h s%b c%b",
                                     rsp.r00, rsp.r01, rsp.r02, rsp.r10, rsp.r11,
                                     rsp.r12, rsp.r20, rsp.r21, rsp.r22,
                                     rsp.singular, rsp.clipped);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule
